// ===== sv/text_console_cursor_engine_unit_defines.svh =====
// Assertion macros shared by the console cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcce_pkg.sv =====
package tcce_pkg;

  localparam int ColW   = 7;
  localparam int RowW   = 6;
  localparam int GlyphW = 7;
  localparam int CharW  = 8;
  localparam int ModeW  = 2;
  localparam int CmdW   = 3;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = QPtrW + 1;

  // Config register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COLS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ROWS   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SHOWN  = 2'd3;

  // Input modes
  localparam logic [ModeW-1:0] MODE_CHAR  = 2'd0;
  localparam logic [ModeW-1:0] MODE_SET   = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

  // Character codes
  localparam logic [CharW-1:0] CH_BS        = 8'h08;
  localparam logic [CharW-1:0] CH_TAB       = 8'h09;
  localparam logic [CharW-1:0] CH_LF        = 8'h0A;
  localparam logic [CharW-1:0] CH_CR        = 8'h0D;
  localparam logic [CharW-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [CharW-1:0] CH_PRINT_HI  = 8'h7E;
  localparam logic [GlyphW-1:0] GLYPH_SPACE = 7'h20;
  localparam logic [GlyphW-1:0] GLYPH_NONE  = 7'h00;

  typedef enum logic [CmdW-1:0] {
    CMD_ERASE_CUR  = 3'd0,
    CMD_GLYPH      = 3'd1,
    CMD_ERASE_CELL = 3'd2,
    CMD_SCROLL     = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_DRAW_CUR   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_LF,
    OP_CR,
    OP_BS,
    OP_TAB,
    OP_CHAR,
    OP_SET,
    OP_CLEAR
  } op_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_START,
    B_ERASE,
    B_MOVE,
    B_GLYPH,
    B_SCROLL,
    B_ECELL,
    B_CLEAR,
    B_DRAW
  } back_state_e;

  typedef struct packed {
    logic             enable;
    logic [7:0]       screen_cols;
    logic [6:0]       screen_rows;
    logic             cursor_shown;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [GlyphW-1:0] glyph;
    logic [ColW-1:0]  set_col;
    logic [RowW-1:0]  set_row;
  } op_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/tcce_front.sv =====
module tcce_front (
  input  logic                      enable_i,
  input  logic [tcce_pkg::ModeW-1:0] mode_i,
  input  logic [tcce_pkg::CharW-1:0] char_code_i,
  input  logic [tcce_pkg::ColW-1:0] set_col_i,
  input  logic [tcce_pkg::RowW-1:0] set_row_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tcce_pkg::q_status_t       q_status_i,
  output logic                      push_o,
  output tcce_pkg::op_t             entry_o
);

  logic keep;

  assign in_ready_o = ~q_status_i.full;

  always_comb begin
    keep            = 1'b0;
    entry_o.op      = tcce_pkg::OP_CHAR;
    entry_o.glyph   = char_code_i[tcce_pkg::GlyphW-1:0];
    entry_o.set_col = set_col_i;
    entry_o.set_row = set_row_i;
    case (mode_i)
      tcce_pkg::MODE_CHAR: begin
        keep = 1'b1;
        if (char_code_i == tcce_pkg::CH_LF) begin
          entry_o.op = tcce_pkg::OP_LF;
        end else if (char_code_i == tcce_pkg::CH_CR) begin
          entry_o.op = tcce_pkg::OP_CR;
        end else if (char_code_i == tcce_pkg::CH_BS) begin
          entry_o.op = tcce_pkg::OP_BS;
        end else if (char_code_i == tcce_pkg::CH_TAB) begin
          entry_o.op = tcce_pkg::OP_TAB;
        end else if (char_code_i inside {[tcce_pkg::CH_PRINT_LO:tcce_pkg::CH_PRINT_HI]}) begin
          entry_o.op = tcce_pkg::OP_CHAR;
        end else begin
          // drop NUL, other controls and high bytes
          keep = 1'b0;
        end
      end
      tcce_pkg::MODE_SET: begin
        keep       = 1'b1;
        entry_o.op = tcce_pkg::OP_SET;
      end
      tcce_pkg::MODE_CLEAR: begin
        keep       = 1'b1;
        entry_o.op = tcce_pkg::OP_CLEAR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_o = in_valid_i & in_ready_o & keep & enable_i;

endmodule

// ===== sv/tcce_queue.sv =====
`include "text_console_cursor_engine_unit_defines.svh"

module tcce_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tcce_pkg::op_t       entry_i,
  input  logic                pop_i,
  output tcce_pkg::op_t       head_o,
  output tcce_pkg::q_status_t status_o
);

  tcce_pkg::op_t                  mem_q [tcce_pkg::QueueDepth];
  logic [tcce_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tcce_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tcce_pkg::QCntW-1:0]     count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == tcce_pkg::QCntW'(tcce_pkg::QueueDepth));

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `TCCE_ASSERT_NOW(a_no_overflow, push_i, !status_o.full || pop_i, "queue push while full")
  `TCCE_ASSERT_NOW(a_no_underflow, pop_i, !status_o.empty, "queue pop while empty")

endmodule

// ===== sv/tcce_back.sv =====
`include "text_console_cursor_engine_unit_defines.svh"

module tcce_back #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcce_pkg::cfg_t              cfg_i,
  input  tcce_pkg::q_status_t         q_status_i,
  input  tcce_pkg::op_t               head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcce_pkg::CmdW-1:0]   command_o,
  output logic [tcce_pkg::ColW-1:0]   cell_col_o,
  output logic [tcce_pkg::RowW-1:0]   cell_row_o,
  output logic [tcce_pkg::GlyphW-1:0] glyph_o,
  output logic                        run_end_o
);

  localparam int ColCap  = (MAX_COLS < 128) ? MAX_COLS : 128;
  localparam int RowCap  = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int ColSpan = 2 ** tcce_pkg::ColW;

  tcce_pkg::back_state_e state_q, state_d;
  tcce_pkg::back_state_e nxt;
  tcce_pkg::back_state_e done_state;

  logic [tcce_pkg::ColW-1:0] col_q, col_d, col_inc;
  logic [tcce_pkg::RowW-1:0] line_q, line_d;
  tcce_pkg::op_t             op_q, op_d;
  logic                      shown_q, shown_d;
  logic [tcce_pkg::ColW-1:0] last_col_q, last_col_d, eff_last_col;
  logic [tcce_pkg::RowW-1:0] last_row_q, last_row_d, eff_last_row;
  logic [7:0]                cols_eff;
  logic [6:0]                rows_eff;
  logic                      at_right, at_bottom;

  logic                        emit_ok, load;
  tcce_pkg::cmd_e              ld_cmd;
  logic [tcce_pkg::ColW-1:0]   ld_col;
  logic [tcce_pkg::RowW-1:0]   ld_row;
  logic [tcce_pkg::GlyphW-1:0] ld_glyph;

  logic                        out_valid_q;
  tcce_pkg::cmd_e              out_cmd_q;
  logic [tcce_pkg::ColW-1:0]   out_col_q;
  logic [tcce_pkg::RowW-1:0]   out_row_q;
  logic [tcce_pkg::GlyphW-1:0] out_glyph_q;
  logic                        out_last_q;

  // Column positions that are tab stops
  logic [ColSpan-1:0] tab_stop_at;
  for (genvar g = 0; g < ColSpan; g++) begin : g_tab
    assign tab_stop_at[g] = ((g % TAB_STOP) == 0);
  end

  // Saturate the screen size to 1..cap
  always_comb begin
    cols_eff = cfg_i.screen_cols;
    if (cols_eff == 8'd0) begin
      cols_eff = 8'd1;
    end else if (cols_eff > 8'(ColCap)) begin
      cols_eff = 8'(ColCap);
    end
    rows_eff = cfg_i.screen_rows;
    if (rows_eff == 7'd0) begin
      rows_eff = 7'd1;
    end else if (rows_eff > 7'(RowCap)) begin
      rows_eff = 7'(RowCap);
    end
  end

  assign eff_last_col = tcce_pkg::ColW'(cols_eff - 8'd1);
  assign eff_last_row = tcce_pkg::RowW'(rows_eff - 7'd1);

  assign col_inc    = col_q + 1'b1;
  assign at_right   = (col_q == last_col_q);
  assign at_bottom  = (line_q == last_row_q);
  assign done_state = shown_q ? tcce_pkg::B_DRAW : tcce_pkg::B_IDLE;
  assign emit_ok    = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d    = state_q;
    nxt        = state_q;
    col_d      = col_q;
    line_d     = line_q;
    op_d       = op_q;
    shown_d    = shown_q;
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    ld_cmd     = tcce_pkg::CMD_ERASE_CUR;
    ld_col     = col_q;
    ld_row     = line_q;
    ld_glyph   = tcce_pkg::GLYPH_NONE;

    case (state_q)
      tcce_pkg::B_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o      = 1'b1;
          op_d       = head_i;
          shown_d    = cfg_i.cursor_shown;
          last_col_d = eff_last_col;
          last_row_d = eff_last_row;
          // pull a cursor left outside by a resize back onto the screen
          col_d      = (col_q > eff_last_col) ? eff_last_col : col_q;
          line_d     = (line_q > eff_last_row) ? eff_last_row : line_q;
          state_d    = tcce_pkg::B_START;
        end
      end
      tcce_pkg::B_START: begin
        case (op_q.op)
          tcce_pkg::OP_CLEAR: state_d = tcce_pkg::B_CLEAR;
          tcce_pkg::OP_BS: begin
            if (col_q == '0) begin
              state_d = tcce_pkg::B_IDLE;
            end else begin
              state_d = shown_q ? tcce_pkg::B_ERASE : tcce_pkg::B_MOVE;
            end
          end
          default: state_d = shown_q ? tcce_pkg::B_ERASE : tcce_pkg::B_MOVE;
        endcase
      end
      tcce_pkg::B_ERASE: begin
        if (emit_ok) begin
          load    = 1'b1;
          ld_cmd  = tcce_pkg::CMD_ERASE_CUR;
          nxt     = tcce_pkg::B_MOVE;
          state_d = nxt;
        end
      end
      tcce_pkg::B_MOVE: begin
        case (op_q.op)
          tcce_pkg::OP_LF: begin
            col_d = '0;
            if (at_bottom) begin
              state_d = tcce_pkg::B_SCROLL;
            end else begin
              line_d  = line_q + 1'b1;
              state_d = done_state;
            end
          end
          tcce_pkg::OP_CR: begin
            col_d   = '0;
            state_d = done_state;
          end
          tcce_pkg::OP_SET: begin
            col_d   = (op_q.set_col > last_col_q) ? last_col_q : op_q.set_col;
            line_d  = (op_q.set_row > last_row_q) ? last_row_q : op_q.set_row;
            state_d = done_state;
          end
          tcce_pkg::OP_BS:    state_d = tcce_pkg::B_ECELL;
          tcce_pkg::OP_TAB:   state_d = tcce_pkg::B_GLYPH;
          tcce_pkg::OP_CHAR:  state_d = tcce_pkg::B_GLYPH;
          tcce_pkg::OP_CLEAR: state_d = tcce_pkg::B_CLEAR;
          default:            state_d = tcce_pkg::B_IDLE;
        endcase
      end
      tcce_pkg::B_GLYPH: begin
        if (emit_ok) begin
          load     = 1'b1;
          ld_cmd   = tcce_pkg::CMD_GLYPH;
          ld_glyph = (op_q.op == tcce_pkg::OP_TAB) ? tcce_pkg::GLYPH_SPACE : op_q.glyph;
          if (at_right) begin
            // wrap; a tab ends here too
            col_d = '0;
            if (at_bottom) begin
              nxt = tcce_pkg::B_SCROLL;
            end else begin
              line_d = line_q + 1'b1;
              nxt    = done_state;
            end
          end else begin
            col_d = col_inc;
            if (op_q.op == tcce_pkg::OP_TAB && !tab_stop_at[col_inc]) begin
              nxt = tcce_pkg::B_GLYPH;
            end else begin
              nxt = done_state;
            end
          end
          state_d = nxt;
        end
      end
      tcce_pkg::B_SCROLL: begin
        if (emit_ok) begin
          load    = 1'b1;
          ld_cmd  = tcce_pkg::CMD_SCROLL;
          ld_col  = '0;
          ld_row  = '0;
          nxt     = done_state;
          state_d = nxt;
        end
      end
      tcce_pkg::B_ECELL: begin
        if (emit_ok) begin
          load    = 1'b1;
          ld_cmd  = tcce_pkg::CMD_ERASE_CELL;
          col_d   = col_q - 1'b1;
          ld_col  = col_q - 1'b1;
          nxt     = done_state;
          state_d = nxt;
        end
      end
      tcce_pkg::B_CLEAR: begin
        if (emit_ok) begin
          load    = 1'b1;
          ld_cmd  = tcce_pkg::CMD_CLEAR;
          ld_col  = '0;
          ld_row  = '0;
          col_d   = '0;
          line_d  = '0;
          nxt     = done_state;
          state_d = nxt;
        end
      end
      tcce_pkg::B_DRAW: begin
        if (emit_ok) begin
          load    = 1'b1;
          ld_cmd  = tcce_pkg::CMD_DRAW_CUR;
          nxt     = tcce_pkg::B_IDLE;
          state_d = nxt;
        end
      end
      default: state_d = tcce_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcce_pkg::B_IDLE;
      col_q       <= '0;
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      line_q  <= line_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    shown_q    <= shown_d;
    last_col_q <= last_col_d;
    last_row_q <= last_row_d;
    if (load) begin
      out_cmd_q   <= ld_cmd;
      out_col_q   <= ld_col;
      out_row_q   <= ld_row;
      out_glyph_q <= ld_glyph;
      // the run ends when the sequencer goes back to idle
      out_last_q  <= (nxt == tcce_pkg::B_IDLE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o   = out_cmd_q;
  assign cell_col_o  = out_col_q;
  assign cell_row_o  = out_row_q;
  assign glyph_o     = out_glyph_q;
  assign run_end_o   = out_last_q;

  `TCCE_ASSERT_NOW(a_erase_needs_shown, state_q == tcce_pkg::B_ERASE, shown_q, "cursor erase while hidden")
  `TCCE_ASSERT_NOW(a_cursor_on_screen, state_q != tcce_pkg::B_IDLE, (col_q <= last_col_q) && (line_q <= last_row_q), "cursor off screen")
  `TCCE_ASSERT_NEXT(a_last_to_idle, load && (nxt == tcce_pkg::B_IDLE), state_q == tcce_pkg::B_IDLE, "run end without return to idle")

endmodule

// ===== sv/text_console_cursor_engine_unit.sv =====
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser: mode; tdata: char, set col, set row
// m_axis    out  m_axis_tvalid/tready      tuser: command; tdata: col, row, glyph; tlast
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// An accepted item is classified in the same cycle and queued (4 entries); ignored codes,
// the unused mode and every item while the console is off are dropped at the input.
// The back sequencer fetches and dispatches an item, issues at most one command per cycle,
// and moves the cursor in its own state (not for clear): a printable character with the
// cursor shown issues erase, glyph and draw commands, a backspace at column 0 issues none.
// Output stalls hold the sequencer; the input stalls once the queue is full.
// Reset puts the cursor at 0,0 and the registers at enable, 80x25, cursor shown.
module text_console_cursor_engine_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] char_code, [14:8] set_col, [20:15] set_row
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] cell_col, [12:7] cell_row, [19:13] glyph
  output logic [2:0]  m_axis_tuser,   // [2:0] command
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [tcce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  tcce_pkg::cfg_t      cfg_q;
  tcce_pkg::q_status_t q_status;
  tcce_pkg::op_t       entry, head;
  logic                push, pop;
  logic [tcce_pkg::ColW-1:0]   cell_col;
  logic [tcce_pkg::RowW-1:0]   cell_row;
  logic [tcce_pkg::GlyphW-1:0] glyph;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b1;
      cfg_q.screen_cols  <= 8'd80;
      cfg_q.screen_rows  <= 7'd25;
      cfg_q.cursor_shown <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tcce_pkg::REG_ENABLE: cfg_q.enable       <= cfg_data_i[0];
        tcce_pkg::REG_COLS:   cfg_q.screen_cols  <= cfg_data_i;
        tcce_pkg::REG_ROWS:   cfg_q.screen_rows  <= cfg_data_i[6:0];
        tcce_pkg::REG_SHOWN:  cfg_q.cursor_shown <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcce_front u_front (
    .enable_i    (cfg_q.enable),
    .mode_i      (s_axis_tuser),
    .char_code_i (s_axis_tdata[7:0]),
    .set_col_i   (s_axis_tdata[14:8]),
    .set_row_i   (s_axis_tdata[20:15]),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .q_status_i  (q_status),
    .push_o      (push),
    .entry_o     (entry)
  );

  tcce_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  tcce_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .command_o   (m_axis_tuser),
    .cell_col_o  (cell_col),
    .cell_row_o  (cell_row),
    .glyph_o     (glyph),
    .run_end_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, glyph, cell_row, cell_col};

endmodule
